>>> sv/arts_pkg.sv
// ----------------------------------------------------------------------------
// arts_pkg: shared types and constants of the address range table scanner
// Result codes, header constants and the structs passed between the input
// stage, the scan core and the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package arts_pkg;

   typedef logic [1:0] status_type;

   localparam status_type ST_FOUND   = 2'd0;
   localparam status_type ST_NONE    = 2'd1;
   localparam status_type ST_CORRUPT = 2'd2;

   // A 32-bit length at or above this value is reserved or an escape.
   localparam logic [31:0] LEN_RESERVED_MIN = 32'hffff_fff0;
   localparam logic [31:0] ESCAPE_64        = 32'hffff_ffff;
   localparam logic [15:0] ARANGES_VERSION  = 16'd2;

   typedef struct packed {
      logic       last;
      logic [7:0] data_byte;
   } step_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] cu_offset;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/arts_scan.sv
// ----------------------------------------------------------------------------
// arts_scan: byte-wise parser and range compare
// Holds the scan state of one section and turns each section byte into
// at most one result, combinationally from the registered scan state.
// ----------------------------------------------------------------------------
`default_nettype none

module arts_scan #(
   parameter int MAX_ADDR_BYTES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_valid,
   input  wire arts_pkg::step_type step,
   input  wire logic [63:0]       target_pc,
   output      logic              res_valid,
   output      arts_pkg::rsp_type res
);

   typedef enum logic [3:0] {
      PH_LEN32   = 4'd0,
      PH_LEN64   = 4'd1,
      PH_VERSION = 4'd2,
      PH_OFF32   = 4'd3,
      PH_OFF64   = 4'd4,
      PH_ASIZE   = 4'd5,
      PH_SSIZE   = 4'd6,
      PH_PAD     = 4'd7,
      PH_TSTART  = 4'd8,
      PH_TLEN    = 4'd9,
      PH_SKIP    = 4'd10
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] position_ff, position_in;
   logic [63:0] unit_end_ff, unit_end_in;
   logic [63:0] accum_ff, accum_in;
   logic [3:0]  left_ff, left_in;
   logic [3:0]  asize_ff, asize_in;
   logic [63:0] info_off_ff, info_off_in;
   logic [63:0] range_start_ff, range_start_in;
   logic        finished_ff, finished_in;

   logic [63:0] npos;
   logic [3:0]  width;
   logic [3:0]  cnt;
   logic [3:0]  cnt_dec;
   logic        field_done;
   logic [63:0] acc_shift;
   logic [63:0] value;
   logic [64:0] end_sum;
   logic [63:0] end_sat;
   logic [63:0] range_end;
   logic [3:0]  asz;
   logic [4:0]  tuple;
   logic [4:0]  tmask;
   logic [4:0]  pad5;

   always_comb begin
      npos = position_ff + 64'd1;

      case (phase_ff)
         PH_LEN32, PH_OFF32: width = 4'd4;
         PH_LEN64, PH_OFF64: width = 4'd8;
         PH_VERSION:         width = 4'd2;
         default:            width = (asize_ff != 4'd0 && asize_ff <= 4'd8) ? asize_ff : 4'd1;
      endcase

      cnt        = (left_ff == 4'd0 || left_ff > width) ? width : left_ff;
      cnt_dec    = cnt - 4'd1;
      field_done = (cnt_dec == 4'd0);
      acc_shift  = {step.data_byte, accum_ff[63:8]};

      // The field is collected from the top, so its value sits left-aligned.
      case (width)
         4'd1:    value = {56'd0, acc_shift[63:56]};
         4'd2:    value = {48'd0, acc_shift[63:48]};
         4'd4:    value = {32'd0, acc_shift[63:32]};
         default: value = acc_shift;
      endcase

      end_sum   = {1'b0, npos} + {1'b0, value};
      end_sat   = end_sum[64] ? {64{1'b1}} : end_sum[63:0];
      range_end = range_start_ff + value;

      asz   = (asize_ff == 4'd0) ? 4'd1 : asize_ff;
      tuple = {asz, 1'b0};
      tmask = tuple - 5'd1;
      pad5  = (tuple - (npos[4:0] & tmask)) & tmask;
   end

   always_comb begin
      phase_in       = phase_ff;
      position_in    = position_ff;
      unit_end_in    = unit_end_ff;
      accum_in       = accum_ff;
      left_in        = left_ff;
      asize_in       = asize_ff;
      info_off_in    = info_off_ff;
      range_start_in = range_start_ff;
      finished_in    = finished_ff;
      res_valid      = 1'b0;
      res.status     = arts_pkg::ST_NONE;
      res.cu_offset  = 64'd0;

      if (step_valid) begin
         if (!finished_ff) begin
            case (phase_ff)
               PH_LEN32, PH_LEN64, PH_VERSION, PH_OFF32, PH_OFF64,
               PH_TSTART, PH_TLEN: begin
                  accum_in = acc_shift;
                  left_in  = cnt_dec;
               end
               default: begin
               end
            endcase

            case (phase_ff)
               PH_LEN32: begin
                  if (field_done) begin
                     if (value[31:0] >= arts_pkg::LEN_RESERVED_MIN) begin
                        if (value[31:0] == arts_pkg::ESCAPE_64) begin
                           phase_in = PH_LEN64;
                           left_in  = 4'd0;
                           accum_in = 64'd0;
                        end else begin
                           res_valid  = 1'b1;
                           res.status = arts_pkg::ST_CORRUPT;
                        end
                     end else if (value < 64'd2) begin
                        res_valid = 1'b1;
                     end else begin
                        unit_end_in = end_sat;
                        phase_in    = PH_VERSION;
                        left_in     = 4'd0;
                        accum_in    = 64'd0;
                     end
                  end
               end
               PH_LEN64: begin
                  if (field_done) begin
                     if (value < 64'd2) begin
                        res_valid = 1'b1;
                     end else begin
                        unit_end_in = end_sat;
                        phase_in    = PH_VERSION;
                        left_in     = 4'd0;
                        accum_in    = 64'd0;
                     end
                  end
               end
               PH_VERSION: begin
                  if (field_done) begin
                     if (value[15:0] != arts_pkg::ARANGES_VERSION) begin
                        res_valid  = 1'b1;
                        res.status = arts_pkg::ST_CORRUPT;
                     end else begin
                        phase_in = PH_OFF32;
                        left_in  = 4'd0;
                        accum_in = 64'd0;
                     end
                  end
               end
               PH_OFF32: begin
                  if (field_done) begin
                     if (value[31:0] == arts_pkg::ESCAPE_64) begin
                        phase_in = PH_OFF64;
                     end else begin
                        info_off_in = value;
                        phase_in    = PH_ASIZE;
                     end
                     left_in  = 4'd0;
                     accum_in = 64'd0;
                  end
               end
               PH_OFF64: begin
                  if (field_done) begin
                     info_off_in = value;
                     phase_in    = PH_ASIZE;
                     left_in     = 4'd0;
                     accum_in    = 64'd0;
                  end
               end
               PH_ASIZE: begin
                  if ((step.data_byte inside {8'd1, 8'd2, 8'd4, 8'd8}) &&
                      step.data_byte <= 8'(MAX_ADDR_BYTES)) begin
                     asize_in = step.data_byte[3:0];
                     phase_in = PH_SSIZE;
                     left_in  = 4'd0;
                     accum_in = 64'd0;
                  end else begin
                     res_valid  = 1'b1;
                     res.status = arts_pkg::ST_CORRUPT;
                  end
               end
               PH_SSIZE: begin
                  if (step.data_byte != 8'd0) begin
                     res_valid  = 1'b1;
                     res.status = arts_pkg::ST_CORRUPT;
                  end else if (pad5 != 5'd0) begin
                     phase_in = PH_PAD;
                     left_in  = pad5[3:0];
                  end else begin
                     phase_in = PH_TSTART;
                     left_in  = 4'd0;
                     accum_in = 64'd0;
                  end
               end
               PH_PAD: begin
                  if (left_ff <= 4'd1) begin
                     phase_in = PH_TSTART;
                     left_in  = 4'd0;
                     accum_in = 64'd0;
                  end else begin
                     left_in = left_ff - 4'd1;
                  end
               end
               PH_TSTART: begin
                  if (field_done) begin
                     range_start_in = value;
                     phase_in       = PH_TLEN;
                     left_in        = 4'd0;
                     accum_in       = 64'd0;
                  end
               end
               PH_TLEN: begin
                  if (field_done) begin
                     if (range_start_ff == 64'd0 && value == 64'd0) begin
                        // End of this unit's tuples: skip what is left of it.
                        phase_in = (unit_end_ff > npos) ? PH_SKIP : PH_LEN32;
                        left_in  = 4'd0;
                        accum_in = 64'd0;
                     end else if (target_pc >= range_start_ff && target_pc < range_end) begin
                        res_valid     = 1'b1;
                        res.status    = arts_pkg::ST_FOUND;
                        res.cu_offset = info_off_ff;
                     end else begin
                        phase_in = PH_TSTART;
                        left_in  = 4'd0;
                        accum_in = 64'd0;
                     end
                  end
               end
               PH_SKIP: begin
                  if (npos >= unit_end_ff) begin
                     phase_in = PH_LEN32;
                     left_in  = 4'd0;
                     accum_in = 64'd0;
                  end
               end
               default: begin
                  phase_in = PH_LEN32;
                  left_in  = 4'd0;
                  accum_in = 64'd0;
               end
            endcase
            position_in = npos;

            if (step.last && !res_valid) begin
               res_valid  = 1'b1;
               res.status = arts_pkg::ST_NONE;
            end
         end

         if (step.last) begin
            phase_in       = PH_LEN32;
            position_in    = 64'd0;
            unit_end_in    = 64'd0;
            accum_in       = 64'd0;
            left_in        = 4'd0;
            asize_in       = 4'd0;
            info_off_in    = 64'd0;
            range_start_in = 64'd0;
            finished_in    = 1'b0;
         end else if (res_valid) begin
            finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEN32;
         position_ff    <= 64'd0;
         unit_end_ff    <= 64'd0;
         accum_ff       <= 64'd0;
         left_ff        <= 4'd0;
         asize_ff       <= 4'd0;
         info_off_ff    <= 64'd0;
         range_start_ff <= 64'd0;
         finished_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         unit_end_ff    <= unit_end_in;
         accum_ff       <= accum_in;
         left_ff        <= left_in;
         asize_ff       <= asize_in;
         info_off_ff    <= info_off_in;
         range_start_ff <= range_start_in;
         finished_ff    <= finished_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/arts_rsp_buf.sv
// ----------------------------------------------------------------------------
// arts_rsp_buf: two-entry result buffer
// Holds results until the receiver takes them; the full flag is registered
// so that the receiver's ready never reaches the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module arts_rsp_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire arts_pkg::rsp_type push_data,
   output      logic              full,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      arts_pkg::rsp_type rsp_data
);

   logic              head_valid_ff, head_valid_in;
   logic              spare_valid_ff, spare_valid_in;
   arts_pkg::rsp_type head_ff, head_in;
   arts_pkg::rsp_type spare_ff, spare_in;
   logic              pop;

   assign pop       = head_valid_ff && rsp_ready;
   assign full      = head_valid_ff && spare_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

   always_comb begin
      head_valid_in  = head_valid_ff;
      spare_valid_in = spare_valid_ff;
      head_in        = head_ff;
      spare_in       = spare_ff;
      if (pop) begin
         if (spare_valid_ff) begin
            head_in        = spare_ff;
            spare_valid_in = push;
            spare_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (!head_valid_ff) begin
         head_valid_in = push;
         head_in       = push_data;
      end else if (push) begin
         spare_valid_in = 1'b1;
         spare_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         head_valid_ff  <= head_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

endmodule

`default_nettype wire

>>> sv/address_range_table_scanner.sv
// ----------------------------------------------------------------------------
// address_range_table_scanner: address range section lookup
// Scans an address range section byte by byte for the unit covering an
// address and reports found with the unit offset, not found, or corrupt.
// ----------------------------------------------------------------------------
// Usage:
// The csr_ channel writes target_pc; write it only while no section is in
// progress. Section bytes enter on the req_ channel, little-endian, one item
// per byte, with req_last on the final byte. Each section yields exactly one
// item on the rsp_ channel: status and, when found, the unit's info offset.
// A byte is taken every cycle unless the input stalls; the scan state is
// updated by combinational logic behind the input register, and the result
// of a byte goes through the result buffer register before it is offered.
// Bytes after a result are consumed and ignored until the last byte, which
// rearms the scanner. Results wait in a two-entry buffer; input stalls only
// once both entries are full and a byte is held in the input register.
// Reset clears the scan state and sets target_pc to zero; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_table_scanner #(
   parameter int MAX_ADDR_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [63:0] csr_target_pc,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic [63:0] rsp_cu_offset
);

   logic [63:0]        target_pc_ff;
   logic               in_valid_ff, in_valid_in;
   arts_pkg::step_type in_step_ff, in_step_in;
   logic               buf_full;
   logic               step_valid;
   logic               res_valid;
   arts_pkg::rsp_type  res;
   arts_pkg::rsp_type  out_data;
   logic               req_take;

   assign csr_ready  = 1'b1;
   assign step_valid = in_valid_ff && !buf_full;
   assign req_ready  = !in_valid_ff || !buf_full;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_step_in  = in_step_ff;
      if (req_take) begin
         in_valid_in          = 1'b1;
         in_step_in.data_byte = req_data_byte;
         in_step_in.last      = req_last;
      end else if (step_valid) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_pc_ff <= 64'd0;
         in_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            target_pc_ff <= csr_target_pc;
         end
         in_valid_ff <= in_valid_in;
      end
      in_step_ff <= in_step_in;
   end

   arts_scan #(
      .MAX_ADDR_BYTES(MAX_ADDR_BYTES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step       (in_step_ff),
      .target_pc  (target_pc_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   arts_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_data)
   );

   assign rsp_status    = out_data.status;
   assign rsp_cu_offset = out_data.cu_offset;

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: address range table scanner
// Streams address range sections into the scanner one byte per item and
// checks every lookup result against a predictor of the scan. A few
// hand-built sections come first: header errors, wide fields, padding, unit
// skips, truncation and range boundaries. Random sections follow under
// several target_pc settings and three patterns of idle cycles.
// ----------------------------------------------------------------------------

typedef enum logic [3:0] {
   S_LEN, S_LEN_WIDE, S_VERSION, S_OFFSET, S_OFFSET_WIDE, S_ADDR_SIZE,
   S_SEG_SIZE, S_PAD, S_START, S_SPAN, S_SKIP
} scan_phase_type;

class lookup_scoreboard;
   logic [63:0] target_pc;
   int unsigned max_addr_bytes;
   scan_phase_type phase;
   logic [63:0] byte_pos, unit_limit, shift_reg, cu_base, tuple_start;
   int unsigned bytes_to_go, addr_bytes;
   bit answered;
   arts_pkg::rsp_type expected_lookups[$];
   int unsigned error_count, found_count, none_count, corrupt_count;

   function new(int unsigned addr_limit);
      max_addr_bytes = addr_limit;
      target_pc = '0;
      error_count = 0;
      found_count = 0;
      none_count = 0;
      corrupt_count = 0;
      rearm();
   endfunction

   function void rearm();
      phase = S_LEN;
      byte_pos = '0;
      unit_limit = '0;
      shift_reg = '0;
      bytes_to_go = 0;
      addr_bytes = 0;
      cu_base = '0;
      tuple_start = '0;
      answered = 1'b0;
   endfunction

   function void open_field(scan_phase_type next_phase);
      phase = next_phase;
      bytes_to_go = 0;
      shift_reg = '0;
   endfunction

   function int unsigned field_width();
      case (phase)
         S_LEN, S_OFFSET: return 4;
         S_LEN_WIDE, S_OFFSET_WIDE: return 8;
         S_VERSION: return 2;
         default: return (addr_bytes >= 1 && addr_bytes <= 8) ? addr_bytes : 1;
      endcase
   endfunction

   // Little-endian fields enter at the top of the shift register.
   function bit shift_in(logic [7:0] b, output logic [63:0] value);
      int unsigned n;
      n = field_width();
      value = '0;
      if (bytes_to_go == 0 || bytes_to_go > n) bytes_to_go = n;
      shift_reg = {b, shift_reg[63:8]};
      bytes_to_go--;
      if (bytes_to_go != 0) return 1'b0;
      value = shift_reg >> (64 - 8 * n);
      return 1'b1;
   endfunction

   function void set_limit(logic [63:0] from, logic [63:0] len);
      logic [63:0] sum;
      sum = from + len;
      unit_limit = (sum < from) ? '1 : sum;
   endfunction

   function int unsigned outstanding();
      return expected_lookups.size();
   endfunction

   function void note_byte(logic [7:0] b, logic last);
      logic [63:0] npos, v, tuple, pad, tuple_end, off;
      bit fired;
      arts_pkg::status_type st;
      arts_pkg::rsp_type want;
      fired = 1'b0;
      st = arts_pkg::ST_NONE;
      off = '0;
      v = '0;
      if (!answered) begin
         npos = byte_pos + 1;
         case (phase)
            S_LEN: begin
               if (shift_in(b, v)) begin
                  if (v >= {32'd0, arts_pkg::LEN_RESERVED_MIN}) begin
                     if (v == {32'd0, arts_pkg::ESCAPE_64}) begin
                        open_field(S_LEN_WIDE);
                     end else begin
                        fired = 1'b1;
                        st = arts_pkg::ST_CORRUPT;
                     end
                  end else if (v < 2) begin
                     fired = 1'b1;
                     st = arts_pkg::ST_NONE;
                  end else begin
                     set_limit(npos, v);
                     open_field(S_VERSION);
                  end
               end
            end
            S_LEN_WIDE: begin
               if (shift_in(b, v)) begin
                  if (v < 2) begin
                     fired = 1'b1;
                     st = arts_pkg::ST_NONE;
                  end else begin
                     set_limit(npos, v);
                     open_field(S_VERSION);
                  end
               end
            end
            S_VERSION: begin
               if (shift_in(b, v)) begin
                  if (v != {48'd0, arts_pkg::ARANGES_VERSION}) begin
                     fired = 1'b1;
                     st = arts_pkg::ST_CORRUPT;
                  end else begin
                     open_field(S_OFFSET);
                  end
               end
            end
            S_OFFSET: begin
               if (shift_in(b, v)) begin
                  if (v == {32'd0, arts_pkg::ESCAPE_64}) begin
                     open_field(S_OFFSET_WIDE);
                  end else begin
                     cu_base = v;
                     open_field(S_ADDR_SIZE);
                  end
               end
            end
            S_OFFSET_WIDE: begin
               if (shift_in(b, v)) begin
                  cu_base = v;
                  open_field(S_ADDR_SIZE);
               end
            end
            S_ADDR_SIZE: begin
               if ((b == 1 || b == 2 || b == 4 || b == 8) && b <= max_addr_bytes) begin
                  addr_bytes = 32'(b);
                  open_field(S_SEG_SIZE);
               end else begin
                  fired = 1'b1;
                  st = arts_pkg::ST_CORRUPT;
               end
            end
            S_SEG_SIZE: begin
               if (b != 0) begin
                  fired = 1'b1;
                  st = arts_pkg::ST_CORRUPT;
               end else begin
                  // Tuples are aligned to twice the address size from section start.
                  tuple = 64'(2 * ((addr_bytes != 0) ? addr_bytes : 1));
                  pad = (tuple - (npos % tuple)) % tuple;
                  if (pad != 0) begin
                     phase = S_PAD;
                     bytes_to_go = 32'(pad);
                  end else begin
                     open_field(S_START);
                  end
               end
            end
            S_PAD: begin
               if (bytes_to_go > 0) bytes_to_go--;
               if (bytes_to_go == 0) open_field(S_START);
            end
            S_START: begin
               if (shift_in(b, v)) begin
                  tuple_start = v;
                  open_field(S_SPAN);
               end
            end
            S_SPAN: begin
               if (shift_in(b, v)) begin
                  tuple_end = tuple_start + v;
                  if (tuple_start == 0 && v == 0) begin
                     if (unit_limit > npos) open_field(S_SKIP);
                     else open_field(S_LEN);
                  end else if (target_pc >= tuple_start && target_pc < tuple_end) begin
                     fired = 1'b1;
                     st = arts_pkg::ST_FOUND;
                     off = cu_base;
                  end else begin
                     open_field(S_START);
                  end
               end
            end
            S_SKIP: begin
               if (npos >= unit_limit) open_field(S_LEN);
            end
            default: begin
               open_field(S_LEN);
            end
         endcase
         byte_pos = npos;
         if (last && !fired) begin
            fired = 1'b1;
            st = arts_pkg::ST_NONE;
         end
      end
      if (last) rearm();
      else if (fired) answered = 1'b1;
      if (fired) begin
         want.status = st;
         want.cu_offset = (st == arts_pkg::ST_FOUND) ? off : '0;
         expected_lookups.push_back(want);
      end
   endfunction

   task report(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task check_result(arts_pkg::status_type st, logic [63:0] off);
      arts_pkg::rsp_type want;
      if (expected_lookups.size() == 0) begin
         report($sformatf("unexpected result: status %0d offset %h", st, off));
      end else begin
         want = expected_lookups.pop_front();
         if (st !== want.status)
            report($sformatf("status %0d, expected %0d", st, want.status));
         if (off !== want.cu_offset)
            report($sformatf("cu_offset %h, expected %h", off, want.cu_offset));
         case (want.status)
            arts_pkg::ST_FOUND: found_count++;
            arts_pkg::ST_NONE: none_count++;
            default: corrupt_count++;
         endcase
      end
   endtask

   task close_out();
      if (expected_lookups.size() != 0)
         report($sformatf("%0d expected results never arrived", expected_lookups.size()));
   endtask
endclass

module testbench;
   localparam int MAX_ADDR_BYTES = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BYTES = 2000;
   localparam int TARGET_SETTINGS = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [63:0] csr_target_pc = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [63:0] rsp_cu_offset;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_cycles = 0;
   int unsigned sections_sent = 0;
   int unsigned bytes_sent = 0;
   int unsigned settings_written = 0;
   logic [63:0] cur_target = '0;
   logic [7:0] sec_bytes[$];
   lookup_scoreboard lookups = new(MAX_ADDR_BYTES);

   address_range_table_scanner #(
      .MAX_ADDR_BYTES(MAX_ADDR_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_target_pc(csr_target_pc),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_cu_offset(rsp_cu_offset)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) lookups.check_result(rsp_status, rsp_cu_offset);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles.", STALL_LIMIT);
         $display("address_range_table_scanner: mismatch");
         $finish;
      end
   end

   function automatic logic [63:0] field_max(input int unsigned asize);
      return (asize >= 8) ? '1 : (64'd1 << (8 * asize)) - 1;
   endfunction

   function automatic void put_le(input logic [63:0] value, input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         sec_bytes.push_back(value[7:0]);
         value = value >> 8;
      end
   endfunction

   function automatic void put_junk(input int unsigned n);
      repeat (n) sec_bytes.push_back(8'($urandom));
   endfunction

   // Appends one unit. len_mode 0 gives the exact length, 1 one no longer than
   // that, so tuples may run past the unit end, 2 a longer one followed by filler.
   function automatic void add_unit(input bit len64, input bit off64,
                                    input logic [63:0] info_off, input int unsigned asize,
                                    input int unsigned n_tuples, input bit want_hit,
                                    input int unsigned len_mode);
      int unsigned len_at, len_n, body_at, hit_at, n_slots, extra, kind;
      logic [63:0] body, maxv, start, span, k;
      if (len64) put_le({32'd0, arts_pkg::ESCAPE_64}, 4);
      len_at = sec_bytes.size();
      len_n = len64 ? 8 : 4;
      put_le('0, len_n);
      body_at = sec_bytes.size();
      put_le({48'd0, arts_pkg::ARANGES_VERSION}, 2);
      if (off64) begin
         put_le({32'd0, arts_pkg::ESCAPE_64}, 4);
         put_le(info_off, 8);
      end else begin
         if (info_off[31:0] == arts_pkg::ESCAPE_64) info_off[31:0] = '0;
         put_le(info_off, 4);
      end
      sec_bytes.push_back(8'(asize));
      sec_bytes.push_back(8'd0);
      while (sec_bytes.size() % (2 * asize) != 0) sec_bytes.push_back(8'($urandom));
      maxv = field_max(asize);
      n_slots = n_tuples + (want_hit ? 1 : 0);
      hit_at = want_hit ? $urandom_range(0, n_tuples) : n_slots;
      for (int unsigned i = 0; i < n_slots; i++) begin
         kind = (i == hit_at) ? 4 : $urandom_range(0, 3);
         case (kind)
            2: begin
               // Range ending exactly at the target.
               k = 64'($urandom_range(1, 64));
               start = cur_target - k;
               span = k;
            end
            3: begin
               start = cur_target + 1;
               span = 64'($urandom_range(1, 64));
            end
            4: begin
               if (cur_target <= maxv) begin
                  k = 64'($urandom_range(0, 64));
                  if (k > cur_target) k = cur_target;
                  start = cur_target - k;
                  span = k + 1 + $urandom_range(0, 64);
                  if (span > maxv) span = maxv;
               end else begin
                  start = {$urandom, $urandom};
                  span = {$urandom, $urandom};
               end
            end
            default: begin
               start = {$urandom, $urandom};
               span = $urandom_range(0, 1) ? {$urandom, $urandom} : $urandom_range(1, 4096);
            end
         endcase
         start = start & maxv;
         span = span & maxv;
         if (start == 0 && span == 0) span = 1;
         put_le(start, asize);
         put_le(span, asize);
      end
      put_le('0, 2 * asize);
      body = 64'(sec_bytes.size() - body_at);
      if (len_mode == 1) begin
         body = body - $urandom_range(0, 32'(body) - 2);
      end else if (len_mode == 2) begin
         extra = $urandom_range(1, 24);
         put_junk(extra);
         body = body + extra;
      end
      for (int unsigned i = 0; i < len_n; i++) sec_bytes[len_at + i] = body[8 * i +: 8];
   endfunction

   function automatic void build_random_section();
      int unsigned n_units, asize, cut, idx;
      logic [63:0] off;
      bit hit;
      sec_bytes.delete();
      if ($urandom_range(0, 99) < 5) begin
         put_junk($urandom_range(1, 40));
      end else begin
         n_units = $urandom_range(1, 3);
         repeat (n_units) begin
            asize = 1 << $urandom_range(0, 3);
            hit = ($urandom_range(0, 2) == 0);
            if (hit) begin
               while (asize < 8 && cur_target > field_max(asize)) asize = asize * 2;
            end
            off = {$urandom, $urandom};
            if ($urandom_range(0, 1)) off = off & 64'hffff;
            add_unit($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, off, asize,
                     $urandom_range(0, 4), hit,
                     ($urandom_range(0, 5) < 4) ? 0 : $urandom_range(1, 2));
         end
         case ($urandom_range(0, 3))
            1: begin
               put_le(64'($urandom_range(0, 1)), 4);
               put_junk($urandom_range(0, 8));
            end
            2: put_junk($urandom_range(1, 8));
            default: ;
         endcase
         if ($urandom_range(0, 9) == 0 && sec_bytes.size() > 1) begin
            cut = $urandom_range(1, sec_bytes.size() - 1);
            while (sec_bytes.size() > cut) void'(sec_bytes.pop_back());
         end
         if ($urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, (sec_bytes.size() > 24) ? 23 : sec_bytes.size() - 1);
            sec_bytes[idx] = 8'($urandom);
         end
      end
   endfunction

   function automatic logic [63:0] pick_target(input int p);
      case (p % 6)
         0: return '0;
         1: return '1;
         2: return 64'($urandom_range(0, 255));
         3: return 64'($urandom_range(0, 65535));
         4: return 64'($urandom);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      lookups.note_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_section();
      foreach (sec_bytes[i]) send_byte(sec_bytes[i], i == sec_bytes.size() - 1);
      sections_sent++;
   endtask

   // A byte after a result gives none of its own, so some settle time
   // follows once the expected results are in.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (lookups.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_target_pc <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      lookups.target_pc = value;
      cur_target = value;
      settings_written++;
   endtask

   task automatic run_directed();
      // Target still at its reset value: a tuple starting at address zero.
      sec_bytes.delete();
      add_unit(0, 0, 64'h11, 1, 0, 1, 0);
      send_section();
      drain_results();
      write_target(64'h1234);
      // Padded header, then both wide fields.
      sec_bytes.delete();
      add_unit(0, 0, 64'habcd, 4, 2, 1, 0);
      send_section();
      sec_bytes.delete();
      add_unit(1, 1, 64'hfedc_ba98_7654_3210, 8, 1, 1, 0);
      send_section();
      // Reserved length, with bytes after the result.
      sec_bytes.delete();
      put_le(64'hffff_fff5, 4);
      put_junk(3);
      send_section();
      sec_bytes.delete();
      put_le(64'd1, 4);
      put_junk(2);
      send_section();
      sec_bytes.delete();
      put_le(64'd0, 4);
      send_section();
      // Bad version, bad address size, bad segment size.
      sec_bytes.delete();
      put_le(64'd12, 4);
      put_le(64'd3, 2);
      send_section();
      sec_bytes.delete();
      put_le(64'd12, 4);
      put_le({48'd0, arts_pkg::ARANGES_VERSION}, 2);
      put_le(64'd5, 4);
      sec_bytes.push_back(8'd3);
      sec_bytes.push_back(8'd0);
      send_section();
      sec_bytes.delete();
      put_le(64'd12, 4);
      put_le({48'd0, arts_pkg::ARANGES_VERSION}, 2);
      put_le(64'd5, 4);
      sec_bytes.push_back(8'd4);
      sec_bytes.push_back(8'd1);
      send_section();
      // Section cut off inside the offset field.
      sec_bytes.delete();
      put_le(64'd20, 4);
      put_le({48'd0, arts_pkg::ARANGES_VERSION}, 2);
      put_le(64'd5, 2);
      send_section();
      // Unit whose length may fall short of its tuples, then a hit in the next one.
      sec_bytes.delete();
      add_unit(0, 0, 64'd1, 2, 2, 0, 1);
      add_unit(0, 0, 64'd2, 2, 1, 1, 0);
      send_section();
      // Long unit skipped after its zero pair, then a hit.
      sec_bytes.delete();
      add_unit(0, 0, 64'd3, 4, 1, 0, 2);
      add_unit(1, 0, 64'd4, 1, 0, 0, 0);
      add_unit(0, 0, 64'd5, 2, 0, 1, 0);
      send_section();
      // Wide length whose unit end saturates; the skip runs to the last byte.
      sec_bytes.delete();
      put_le({32'd0, arts_pkg::ESCAPE_64}, 4);
      put_le('1, 8);
      put_le({48'd0, arts_pkg::ARANGES_VERSION}, 2);
      put_le(64'd9, 4);
      sec_bytes.push_back(8'd2);
      sec_bytes.push_back(8'd0);
      put_le('0, 4);
      put_junk(6);
      send_section();
      sec_bytes.delete();
      sec_bytes.push_back(8'hff);
      send_section();
      // Ranges that end at the target or begin just after it.
      sec_bytes.delete();
      put_le(64'd20, 4);
      put_le({48'd0, arts_pkg::ARANGES_VERSION}, 2);
      put_le(64'h77, 4);
      sec_bytes.push_back(8'd2);
      sec_bytes.push_back(8'd0);
      put_le(64'h1200, 2);
      put_le(64'h34, 2);
      put_le(64'h1235, 2);
      put_le(64'd5, 2);
      put_le('0, 4);
      send_section();
      // At the top of the address space every covering range wraps.
      drain_results();
      write_target('1);
      sec_bytes.delete();
      add_unit(0, 0, 64'd7, 8, 2, 1, 0);
      send_section();
   endtask

   initial begin
      int unsigned random_from;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 32;
      rsp_idle_pct = 75;
      run_directed();
      random_from = bytes_sent;
      for (int p = 0; p < TARGET_SETTINGS; p++) begin
         drain_results();
         write_target(pick_target(p));
         if (p < TARGET_SETTINGS / 3) begin
            req_idle_pct = 32;
            rsp_idle_pct = 75;
         end else if (p < 2 * TARGET_SETTINGS / 3) begin
            req_idle_pct = 75;
            rsp_idle_pct = 32;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         while (bytes_sent - random_from < (p + 1) * RANDOM_BYTES / TARGET_SETTINGS) begin
            build_random_section();
            send_section();
            if ($urandom_range(0, 7) == 0) drain_results();
         end
      end
      drain_results();
      lookups.close_out();
      $display("Sent %0d sections (%0d bytes) under %0d target_pc settings.",
               sections_sent, bytes_sent, settings_written);
      $display("Lookups checked: %0d found, %0d not found, %0d corrupt.",
               lookups.found_count, lookups.none_count, lookups.corrupt_count);
      if (lookups.error_count == 0) begin
         $display("address_range_table_scanner: match");
      end else begin
         $display("address_range_table_scanner: mismatch");
      end
      $finish;
   end
endmodule
